[rtl/dabc_pkg.sv]
// ----------------------------------------------------------------------------
// dabc_pkg
// Types, constants and helpers shared by the depth/area blob check block.
// ----------------------------------------------------------------------------
package dabc_pkg;

	localparam int NUM_REGS        = 8;
	localparam int REG_W           = 24;
	localparam int REG_IDX_W       = 3;
	localparam int COORD_W         = 16;
	localparam int DEPTH_W         = 16;
	localparam int SUM_W           = DEPTH_W + 2;
	localparam int NORM_W          = 2 * COORD_W + 2;
	localparam int ROOT_W          = NORM_W / 2;
	localparam int REM_W           = ROOT_W + 2;
	localparam int SQRT_STEPS      = 3;
	localparam int SQ_STAGES       = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
	localparam int MARGIN_W        = 40;
	localparam int DEF_COORD_FRAC  = 4;
	localparam int DEF_DEPTH_FRAC  = 12;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LO_CUBIC  = 3'd0,
		REG_LO_SQUARE = 3'd1,
		REG_LO_LINEAR = 3'd2,
		REG_LO_OFFSET = 3'd3,
		REG_HI_CUBIC  = 3'd4,
		REG_HI_SQUARE = 3'd5,
		REG_HI_LINEAR = 3'd6,
		REG_HI_OFFSET = 3'd7
	} reg_idx_t;

	localparam logic signed [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		-24'sd295680, 24'sd1396165, -24'sd2189536, 24'sd1096000,
		-24'sd372470, 24'sd1795488, -24'sd2914592, 24'sd1800000
	};

	typedef struct packed {
		logic [COORD_W-1:0] corner0_x;
		logic [COORD_W-1:0] corner0_y;
		logic [COORD_W-1:0] corner1_x;
		logic [COORD_W-1:0] corner1_y;
		logic [COORD_W-1:0] corner2_x;
		logic [COORD_W-1:0] corner2_y;
		logic [DEPTH_W-1:0] depth_at_corner0;
		logic [DEPTH_W-1:0] depth_at_corner1;
		logic [DEPTH_W-1:0] depth_at_corner2;
		logic [DEPTH_W-1:0] depth_at_corner3;
	} blob_in_t;

	typedef struct packed {
		logic                       is_hole;
		logic signed [MARGIN_W-1:0] low_margin;
		logic signed [MARGIN_W-1:0] high_margin;
	} blob_res_t;

	typedef struct packed {
		logic [NORM_W-1:0] rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	// one restoring digit of the integer square root
	function automatic sqrt_state_t sqrt_step(input sqrt_state_t st);
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] trial;
		sqrt_state_t      nx;
		rem     = {st.rem[REM_W-3:0], st.rad[NORM_W-1 -: 2]};
		trial   = {st.root, 2'b01};
		nx.rad  = {st.rad[NORM_W-3:0], 2'b00};
		if (rem >= trial) begin
			nx.rem  = rem - trial;
			nx.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			nx.rem  = rem;
			nx.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return nx;
	endfunction

endpackage

[rtl/dabc_if.sv]
// ----------------------------------------------------------------------------
// dabc_in_if / dabc_out_if
// Valid/ready channels carrying blob records and check results.
// ----------------------------------------------------------------------------
interface dabc_in_if;
	logic              valid;
	logic              ready;
	dabc_pkg::blob_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dabc_out_if;
	logic               valid;
	logic               ready;
	dabc_pkg::blob_res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/depth_area_blob_check_top.sv]
// ----------------------------------------------------------------------------
// depth_area_blob_check_top
// Rectangle area from two square-rooted side lengths, checked against two
// programmable cubic curves of the mean depth.
// ----------------------------------------------------------------------------
// stages: side differences, squared lengths, SQ_STAGES square-root stages,
// product, then the registered output; the root runs three digits per stage.
// throughput: one transaction per cycle; each stage holds only while the
// stage after it is full and stalled.
// reset: valid bits cleared, coefficient registers loaded with defaults.
module depth_area_blob_check_top #(
	parameter int COORD_FRAC_BITS = dabc_pkg::DEF_COORD_FRAC,
	parameter int DEPTH_FRAC_BITS = dabc_pkg::DEF_DEPTH_FRAC
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [dabc_pkg::REG_IDX_W-1:0]          wr_index,
	input  logic [dabc_pkg::REG_W-1:0]              wr_data,
	dabc_in_if.sink                                 blob_in,
	dabc_out_if.source                              blob_out
);
	import dabc_pkg::*;

	localparam int E      = DEPTH_FRAC_BITS + 2;
	localparam int SSW    = SUM_W + 1;
	localparam int P1W    = REG_W + SSW;
	localparam int T1W    = P1W - E + 1;
	localparam int P2W    = T1W + SSW;
	localparam int T2W    = P2W - E + 1;
	localparam int P3W    = T2W + SSW;
	localparam int T3W    = P3W - E + 1;
	localparam int AREA_W = 2 * ROOT_W + 4;
	localparam int DIF_W  = ((T3W > AREA_W + 1) ? T3W : AREA_W + 1) + 1;
	localparam int PS     = 3 + SQ_STAGES;
	localparam int N      = PS + 1;

	// coefficient registers
	logic signed [REG_W-1:0] coef_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) coef_q[i] <= REG_RESET[i];
		end else if (wr_en) begin
			coef_q[wr_index] <= wr_data;
		end
	end

	// valid chain and per-stage enables
	logic [N:1]   vld_q;
	logic [N+1:1] en;

	always_comb begin
		en[N+1] = blob_out.ready;
		for (int k = N; k >= 1; k--) en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= blob_in.valid;
			for (int k = 2; k <= N; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign blob_in.ready = en[1];

	// stage 1: side differences and depth sum
	logic [COORD_W-1:0] dx01_s1, dy01_s1, dx12_s1, dy12_s1;
	logic [SUM_W-1:0]   dsum_s1;

	function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [NORM_W-1:0] sq_sum(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic [2*COORD_W-1:0] a2;
		logic [2*COORD_W-1:0] b2;
		a2 = a * a;
		b2 = b * b;
		return NORM_W'(a2) + NORM_W'(b2);
	endfunction

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dx01_s1 <= absdiff(blob_in.data.corner0_x, blob_in.data.corner1_x);
			dy01_s1 <= absdiff(blob_in.data.corner0_y, blob_in.data.corner1_y);
			dx12_s1 <= absdiff(blob_in.data.corner1_x, blob_in.data.corner2_x);
			dy12_s1 <= absdiff(blob_in.data.corner1_y, blob_in.data.corner2_y);
			dsum_s1 <= SUM_W'(blob_in.data.depth_at_corner0)
				+ SUM_W'(blob_in.data.depth_at_corner1)
				+ SUM_W'(blob_in.data.depth_at_corner2)
				+ SUM_W'(blob_in.data.depth_at_corner3);
		end
	end

	// stage 2: squared lengths, first horner product
	logic [NORM_W-1:0]     n01_s2, n12_s2;
	logic [SUM_W-1:0]      dsum_s2;
	logic signed [P1W-1:0] lo_p1_s2, hi_p1_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n01_s2   <= sq_sum(dx01_s1, dy01_s1);
			n12_s2   <= sq_sum(dx12_s1, dy12_s1);
			dsum_s2  <= dsum_s1;
			lo_p1_s2 <= coef_q[REG_LO_CUBIC] * $signed({1'b0, dsum_s1});
			hi_p1_s2 <= coef_q[REG_HI_CUBIC] * $signed({1'b0, dsum_s1});
		end
	end

	// horner stages 3..5, then t3 is carried to the product stage
	logic signed [P2W-1:0] lo_p2_s3, hi_p2_s3;
	logic [SUM_W-1:0]      dsum_s3;
	logic signed [P3W-1:0] lo_p3_s4, hi_p3_s4;
	logic signed [T3W-1:0] lo_t3_s [5:PS];
	logic signed [T3W-1:0] hi_t3_s [5:PS];
	logic signed [T1W-1:0] lo_t1, hi_t1;
	logic signed [T2W-1:0] lo_t2, hi_t2;

	always_comb begin
		lo_t1 = T1W'(lo_p1_s2 >>> E) + T1W'(coef_q[REG_LO_SQUARE]);
		hi_t1 = T1W'(hi_p1_s2 >>> E) + T1W'(coef_q[REG_HI_SQUARE]);
		lo_t2 = T2W'(lo_p2_s3 >>> E) + T2W'(coef_q[REG_LO_LINEAR]);
		hi_t2 = T2W'(hi_p2_s3 >>> E) + T2W'(coef_q[REG_HI_LINEAR]);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			lo_p2_s3 <= lo_t1 * $signed({1'b0, dsum_s2});
			hi_p2_s3 <= hi_t1 * $signed({1'b0, dsum_s2});
			dsum_s3  <= dsum_s2;
		end
		if (en[4]) begin
			lo_p3_s4 <= lo_t2 * $signed({1'b0, dsum_s3});
			hi_p3_s4 <= hi_t2 * $signed({1'b0, dsum_s3});
		end
		if (en[5]) begin
			lo_t3_s[5] <= T3W'(lo_p3_s4 >>> E) + T3W'(coef_q[REG_LO_OFFSET]);
			hi_t3_s[5] <= T3W'(hi_p3_s4 >>> E) + T3W'(coef_q[REG_HI_OFFSET]);
		end
	end

	for (genvar k = 6; k <= PS; k++) begin : g_t3_dly
		always_ff @(posedge clk) begin
			if (en[k]) begin
				lo_t3_s[k] <= lo_t3_s[k-1];
				hi_t3_s[k] <= hi_t3_s[k-1];
			end
		end
	end

	// square root stages 3..2+SQ_STAGES
	sqrt_state_t sq01_s  [1:SQ_STAGES];
	sqrt_state_t sq12_s  [1:SQ_STAGES];

	for (genvar j = 1; j <= SQ_STAGES; j++) begin : g_sqrt
		sqrt_state_t sq01_in, sq12_in, sq01_nx, sq12_nx;

		if (j == 1) begin : g_head
			assign sq01_in = '{rad: n01_s2, rem: '0, root: '0};
			assign sq12_in = '{rad: n12_s2, rem: '0, root: '0};
		end else begin : g_tail
			assign sq01_in = sq01_s[j-1];
			assign sq12_in = sq12_s[j-1];
		end

		always_comb begin
			sq01_nx = sq01_in;
			sq12_nx = sq12_in;
			for (int i = 0; i < SQRT_STEPS; i++) begin
				if ((j - 1) * SQRT_STEPS + i < ROOT_W) begin
					sq01_nx = sqrt_step(sq01_nx);
					sq12_nx = sqrt_step(sq12_nx);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[2+j]) begin
				sq01_s[j] <= sq01_nx;
				sq12_s[j] <= sq12_nx;
			end
		end
	end

	// product stage
	logic [2*ROOT_W-1:0] prod_s;
	always_ff @(posedge clk) begin
		if (en[PS]) prod_s <= sq01_s[SQ_STAGES].root * sq12_s[SQ_STAGES].root;
	end

	logic [AREA_W-1:0] area;
	if (2 * COORD_FRAC_BITS >= 4) begin : g_area_shr
		assign area = AREA_W'(prod_s >> (2 * COORD_FRAC_BITS - 4));
	end else begin : g_area_shl
		assign area = AREA_W'(prod_s) << (4 - 2 * COORD_FRAC_BITS);
	end

	// output stage: margins with saturation
	logic signed [DIF_W-1:0]    lo_dif, hi_dif;
	logic signed [MARGIN_W-1:0] lo_sat, hi_sat;
	blob_res_t                  res_s;

	function automatic logic signed [MARGIN_W-1:0] sat_margin(
		input logic signed [DIF_W-1:0] v);
		logic [DIF_W-MARGIN_W:0] top;
		top = v[DIF_W-1:MARGIN_W-1];
		if ((&top) || !(|top)) return MARGIN_W'(v);
		return v[DIF_W-1] ? {1'b1, {(MARGIN_W-1){1'b0}}} : {1'b0, {(MARGIN_W-1){1'b1}}};
	endfunction

	always_comb begin
		lo_dif = DIF_W'(lo_t3_s[PS]) - DIF_W'($signed({1'b0, area}));
		hi_dif = DIF_W'(hi_t3_s[PS]) - DIF_W'($signed({1'b0, area}));
		lo_sat = sat_margin(lo_dif);
		hi_sat = sat_margin(hi_dif);
	end

	always_ff @(posedge clk) begin
		if (en[N]) begin
			res_s.low_margin  <= lo_sat;
			res_s.high_margin <= hi_sat;
			res_s.is_hole     <= lo_sat[MARGIN_W-1] && !hi_sat[MARGIN_W-1] && (hi_sat != '0);
		end
	end

	assign blob_out.valid = vld_q[N];
	assign blob_out.data  = res_s;

endmodule

[rtl/dabc_checker.sv]
// ----------------------------------------------------------------------------
// dabc_checker
// Port-level checks for the depth/area blob check block.
// ----------------------------------------------------------------------------
module dabc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               is_hole,
	input logic signed [dabc_pkg::MARGIN_W-1:0] low_margin,
	input logic signed [dabc_pkg::MARGIN_W-1:0] high_margin
);
	import dabc_pkg::*;

	// a result that is not taken stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// flag agrees with the margins it is drawn from
	a_hole_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_hole == (low_margin[MARGIN_W-1] && !high_margin[MARGIN_W-1]
			&& high_margin != '0)))
		else $error("is_hole inconsistent with margins");

	// back pressure only comes from a full, stalled output
	a_stall_src: assert property (@(posedge clk)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back pressure");

	// nothing is offered after reset has been sampled
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

endmodule

bind depth_area_blob_check_top dabc_checker u_dabc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (blob_in.ready),
	.out_valid   (blob_out.valid),
	.out_ready   (blob_out.ready),
	.is_hole     (blob_out.data.is_hole),
	.low_margin  (blob_out.data.low_margin),
	.high_margin (blob_out.data.high_margin)
);
